// ----- rtl/drat_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types for the dump run address translator
package drat_pkg;

    localparam int MAX_RUNS   = 32;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CNT_W = $clog2(MAX_RUNS + 1);

    localparam int RUN_INDEX_W = 5;
    localparam int PAGE_W      = 52;
    localparam int ADDR_W      = 64;
    localparam int LEN_W       = 32;
    localparam int HEADER_W    = 17;
    localparam int RUN_COUNT_W = 6;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 17;

    localparam int S_FIELDS_W = RUN_INDEX_W + 2 * PAGE_W + ADDR_W + LEN_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ADDR_W + LEN_W + 7) / 8) * 8;

    localparam int S_BASE_LO  = RUN_INDEX_W;
    localparam int S_TOTAL_LO = S_BASE_LO + PAGE_W;
    localparam int S_ADDR_LO  = S_TOTAL_LO + PAGE_W;
    localparam int S_LEN_LO   = S_ADDR_LO + ADDR_W;

    localparam logic [CFG_ADDR_W-1:0] REG_DUMP_MODE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RUN_COUNT    = 2'd2;

    localparam logic [HEADER_W-1:0] HEADER_RESET = 17'd4096;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    typedef logic [PAGE_W-1:0] page_t;

endpackage

// ----- rtl/dump_run_address_translator.sv -----
`timescale 1ns / 1ps
// Translates a physical address to a dump file offset by walking a run table.
// A load transaction writes one run entry. A translate transaction walks N run
// entries, at most min(run_count, MAX_RUNS) and fewer when an earlier run hits;
// raw mode and an empty table skip the walk. The next transaction can be taken
// once the result is in the output register, later if the previous result is
// still waiting on m_tready. The walk reads one run entry per cycle from the
// single read port of the run table and tests it with one shared add-and-compare
// unit; a separate adder sums the skipped page counts. Input is not accepted
// during a walk; a finished result waits in the output register while the next
// transaction is taken.
module dump_run_address_translator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // cfg port
    input  logic                                cfg_wr_en,
    input  logic [drat_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [drat_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // run_index, run_base_page, run_page_total, phys_addr, req_len
    input  logic [drat_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd
    input  logic                                s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // file_offset, max_len
    output logic [drat_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit
    output logic                                m_tuser
);
    import drat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic                  dump_mode_reg;
    logic [HEADER_W-1:0]   header_bytes_reg;
    logic [RUN_COUNT_W-1:0] run_count_reg;

    page_t                 base_mem [MAX_RUNS];
    page_t                 len_mem  [MAX_RUNS];
    page_t                 rd_base_reg;
    page_t                 rd_len_reg;
    logic [IDX_W-1:0]      rd_addr;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      idx_reg, idx_inc;
    logic [CNT_W-1:0]      limit_reg, limit_calc;
    logic [ADDR_W-1:0]     addr_reg;
    logic [LEN_W-1:0]      req_len_reg;
    page_t                 skipped_reg;
    page_t                 hit_base_reg;
    logic [PAGE_W:0]       pages_left_reg;
    logic                  hit_reg;

    logic                  m_tvalid_reg;
    logic [ADDR_W-1:0]     m_offset_reg;
    logic [LEN_W-1:0]      m_len_reg;
    logic                  m_hit_reg;

    logic                  s_fire, load_fire, xlate_fire, out_free, walk_last;
    logic [RUN_INDEX_W-1:0] in_index;
    page_t                 in_base, in_total, page_cur;
    logic [PAGE_W:0]       run_end;
    logic                  run_hit;
    page_t                 diff_pages;
    logic [ADDR_W-1:0]     offset_calc, avail;
    logic [LEN_W-1:0]      cap_calc;

    assign in_index = s_tdata[RUN_INDEX_W-1:0];
    assign in_base  = s_tdata[S_BASE_LO +: PAGE_W];
    assign in_total = s_tdata[S_TOTAL_LO +: PAGE_W];

    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign load_fire  = s_fire && (s_tuser == CMD_LOAD);
    assign xlate_fire = s_fire && (s_tuser == CMD_XLATE);
    assign out_free   = !m_tvalid_reg || m_tready;

    assign limit_calc = (run_count_reg > MAX_RUNS) ? CNT_W'(MAX_RUNS) : CNT_W'(run_count_reg);
    assign idx_inc    = idx_reg + CNT_W'(1);
    assign walk_last  = (idx_inc == limit_reg);
    assign rd_addr    = (state_reg == S_WALK) ? idx_inc[IDX_W-1:0] : '0;

    // shared add and compare unit for one run entry
    assign page_cur = addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign run_end  = {1'b0, rd_base_reg} + {1'b0, rd_len_reg};
    assign run_hit  = (page_cur >= rd_base_reg) && ({1'b0, page_cur} < run_end);

    // final offset and length cap
    assign diff_pages  = hit_reg ? (skipped_reg - hit_base_reg) : '0;
    assign offset_calc = addr_reg + {diff_pages, {PAGE_SHIFT{1'b0}}}
                         + ADDR_W'(header_bytes_reg);
    assign avail       = {pages_left_reg[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}}
                         - ADDR_W'(addr_reg[PAGE_SHIFT-1:0]);
    assign cap_calc    = (!pages_left_reg[PAGE_W] && (avail < ADDR_W'(req_len_reg)))
                         ? avail[LEN_W-1:0] : req_len_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (xlate_fire) begin
                    if (dump_mode_reg && (limit_calc != '0)) begin
                        state_next = S_WALK;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK: begin
                if (run_hit || walk_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dump_mode_reg    <= 1'b0;
            header_bytes_reg <= HEADER_RESET;
            run_count_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_DUMP_MODE:    dump_mode_reg    <= cfg_wdata[0];
                REG_HEADER_BYTES: header_bytes_reg <= cfg_wdata[HEADER_W-1:0];
                REG_RUN_COUNT:    run_count_reg    <= cfg_wdata[RUN_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire && (32'(in_index) < MAX_RUNS)) begin
            base_mem[IDX_W'(in_index)] <= in_base;
            len_mem[IDX_W'(in_index)]  <= in_total;
        end
        rd_base_reg <= base_mem[rd_addr];
        rd_len_reg  <= len_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (xlate_fire) begin
            addr_reg    <= s_tdata[S_ADDR_LO +: ADDR_W];
            req_len_reg <= s_tdata[S_LEN_LO +: LEN_W];
            limit_reg   <= limit_calc;
            idx_reg     <= '0;
            skipped_reg <= '0;
            hit_reg     <= 1'b0;
        end else if (state_reg == S_WALK) begin
            idx_reg <= idx_inc;
            if (run_hit) begin
                hit_reg        <= 1'b1;
                hit_base_reg   <= rd_base_reg;
                pages_left_reg <= run_end - {1'b0, page_cur};
            end else begin
                skipped_reg <= skipped_reg + rd_len_reg;
            end
        end
        if (state_reg == S_DONE && out_free) begin
            if (!dump_mode_reg) begin
                m_offset_reg <= addr_reg;
                m_len_reg    <= req_len_reg;
                m_hit_reg    <= 1'b1;
            end else begin
                m_offset_reg <= offset_calc;
                m_len_reg    <= hit_reg ? cap_calc : '0;
                m_hit_reg    <= hit_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_len_reg, m_offset_reg});
    assign m_tuser  = m_hit_reg;

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (idx_reg < limit_reg))
        else $error("run walk index past run limit");

    a_miss_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_W +: LEN_W] == '0))
        else $error("miss result with nonzero length");

    a_raw_no_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (xlate_fire && !dump_mode_reg) |=> (state_reg == S_DONE))
        else $error("raw mode translate entered run walk");

endmodule

// ----- dv/drat_checker.sv -----
`timescale 1ns / 1ps
// checker for the dump run address translator: predicts each translation and compares results
module drat_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [drat_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [drat_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // run_index, run_base_page, run_page_total, phys_addr, req_len
    input  logic [drat_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd
    input  logic                                s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // file_offset, max_len
    input  logic [drat_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit
    input  logic                                m_tuser,
    output int                                  fail_count,
    output int                                  xlat_pending
);
    import drat_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] file_offset;
        logic [LEN_W-1:0]  max_len;
        logic              hit;
    } xlat_result_t;

    page_t                run_base_mem [MAX_RUNS];
    page_t                run_len_mem  [MAX_RUNS];
    logic                 dump_mode_q;
    logic [HEADER_W-1:0]  header_q;
    logic [RUN_COUNT_W-1:0] run_count_q;
    xlat_result_t         xlat_result_q[$];
    int                   errors = 0;

    initial begin
        fail_count   = 0;
        xlat_pending = 0;
    end

    function automatic xlat_result_t translate_addr(input logic [ADDR_W-1:0] addr,
                                                    input logic [LEN_W-1:0] len);
        logic [63:0] page, skipped, base, run_end, pages_left, avail, cap;
        int walk;
        page    = addr >> PAGE_SHIFT;
        skipped = '0;
        if (!dump_mode_q)
            return '{file_offset: addr, max_len: len, hit: 1'b1};
        walk = (int'(run_count_q) > MAX_RUNS) ? MAX_RUNS : int'(run_count_q);
        for (int i = 0; i < walk; i++) begin
            base    = 64'(run_base_mem[i]);
            run_end = base + 64'(run_len_mem[i]);
            if (page >= base && page < run_end) begin
                pages_left = run_end - page;
                cap        = 64'(len);
                if (pages_left <= 64'hFFFF_FFFF_FFFF_FFFF / 64'(PAGE_BYTES)) begin
                    avail = pages_left * 64'(PAGE_BYTES) - 64'(addr[PAGE_SHIFT-1:0]);
                    if (avail < cap)
                        cap = avail;
                end
                return '{file_offset: 64'(header_q) + addr - base * 64'(PAGE_BYTES)
                                      + skipped * 64'(PAGE_BYTES),
                         max_len: cap[LEN_W-1:0], hit: 1'b1};
            end
            skipped += 64'(run_len_mem[i]);
        end
        return '{file_offset: addr + 64'(header_q), max_len: '0, hit: 1'b0};
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        xlat_result_t want;
        xlat_result_t got;
        if (!aresetn) begin
            dump_mode_q  = 1'b0;
            header_q     = HEADER_RESET;
            run_count_q  = '0;
            xlat_result_q.delete();
        end else begin
            // result side first so a result never matches a same-edge input
            if (m_tvalid && m_tready) begin
                got = '{file_offset: m_tdata[ADDR_W-1:0],
                        max_len: m_tdata[ADDR_W +: LEN_W], hit: m_tuser};
                if (xlat_result_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, %s %h len %h hit %b",
                             $time, "actual offset", got.file_offset, got.max_len,
                             got.hit);
                    errors++;
                end else begin
                    want = xlat_result_q.pop_front();
                    compare_field("file_offset", want.file_offset, got.file_offset);
                    compare_field("max_len", 64'(want.max_len), 64'(got.max_len));
                    compare_field("hit", 64'(want.hit), 64'(got.hit));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    if (int'(s_tdata[RUN_INDEX_W-1:0]) < MAX_RUNS) begin
                        run_base_mem[s_tdata[RUN_INDEX_W-1:0]] = s_tdata[S_BASE_LO +: PAGE_W];
                        run_len_mem[s_tdata[RUN_INDEX_W-1:0]]  = s_tdata[S_TOTAL_LO +: PAGE_W];
                    end
                end else begin
                    xlat_result_q.push_back(translate_addr(s_tdata[S_ADDR_LO +: ADDR_W],
                                                           s_tdata[S_LEN_LO +: LEN_W]));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DUMP_MODE:    dump_mode_q = cfg_wdata[0];
                    REG_HEADER_BYTES: header_q    = cfg_wdata[HEADER_W-1:0];
                    REG_RUN_COUNT:    run_count_q = cfg_wdata[RUN_COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count   <= errors;
        xlat_pending <= xlat_result_q.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// top of the testbench for the dump run address translator: stimulus and verdict
module testbench;
    import drat_pkg::*;

    localparam int ITEM_TARGET   = 1650;
    localparam int SETTLE_CYCLES = MAX_RUNS + 16;
    localparam int CYCLE_LIMIT   = 600000;
    localparam page_t PAGE_MAX   = '1;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_DUMP_MODE;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // run_index, run_base_page, run_page_total, phys_addr, req_len
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // cmd
    logic                   s_tuser   = CMD_LOAD;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // file_offset, max_len
    logic [M_TDATA_W-1:0]   m_tdata;
    // hit
    logic                   m_tuser;

    int                     fail_count;
    int                     xlat_pending;
    int unsigned            cycle_count = 0;
    int                     items_sent  = 0;
    bit                     steady      = 1'b0;

    // stimulus-side copy of the run entries and registers, used to aim addresses
    page_t                  loaded_base  [MAX_RUNS];
    page_t                  loaded_pages [MAX_RUNS];
    logic                   cur_mode  = 1'b0;
    logic [RUN_COUNT_W-1:0] cur_count = '0;

    dump_run_address_translator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    drat_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .xlat_pending (xlat_pending)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_word();
        logic [S_TDATA_W-1:0] w;
        for (int k = 0; k < S_TDATA_W; k++)
            w[k] = 1'($urandom_range(0, 1));
        w[S_TDATA_W-1:S_FIELDS_W] = '0;
        return w;
    endfunction

    task automatic put_item(input logic cmd, input logic [S_TDATA_W-1:0] data);
        while (!steady && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic load_run(input logic [RUN_INDEX_W-1:0] idx, input page_t base,
                            input page_t pages);
        logic [S_TDATA_W-1:0] d;
        d = noise_word();
        d[RUN_INDEX_W-1:0]      = idx;
        d[S_BASE_LO +: PAGE_W]  = base;
        d[S_TOTAL_LO +: PAGE_W] = pages;
        loaded_base[idx]  = base;
        loaded_pages[idx] = pages;
        put_item(CMD_LOAD, d);
    endtask

    task automatic xlat_item(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] len);
        logic [S_TDATA_W-1:0] d;
        d = noise_word();
        d[S_ADDR_LO +: ADDR_W] = addr;
        d[S_LEN_LO +: LEN_W]   = len;
        put_item(CMD_XLATE, d);
    endtask

    // wait for every translation to drain, then for SETTLE_CYCLES more
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (xlat_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic mode, input logic [HEADER_W-1:0] hdr,
                              input logic [RUN_COUNT_W-1:0] cnt);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DUMP_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_addr  <= REG_HEADER_BYTES;
        cfg_wdata <= CFG_DATA_W'(hdr);
        @(posedge aclk);
        cfg_addr  <= REG_RUN_COUNT;
        cfg_wdata <= CFG_DATA_W'(cnt);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mode  = mode;
        cur_count = cnt;
    endtask

    function automatic page_t pick_base();
        case ($urandom_range(0, 9))
            0, 1, 2: return page_t'($urandom_range(0, 1023));
            3, 4:    return PAGE_MAX - page_t'($urandom_range(0, 1023));
            default: return page_t'(rand64());
        endcase
    endfunction

    function automatic page_t pick_pages();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PAGE_MAX - page_t'($urandom_range(0, 3));
            2:       return page_t'(rand64());
            3:       return page_t'($urandom_range(1, 1 << 20));
            default: return page_t'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return LEN_W'($urandom_range(1, 8192));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [63:0] page, off;
        logic [PAGE_SHIFT-1:0] byte_off;
        int walk, sel, idx;
        walk = (int'(cur_count) > MAX_RUNS) ? MAX_RUNS : int'(cur_count);
        sel  = $urandom_range(0, 9);
        idx  = (walk > 0) ? $urandom_range(0, walk - 1) : 0;
        case ($urandom_range(0, 3))
            0:       byte_off = '0;
            1:       byte_off = '1;
            default: byte_off = PAGE_SHIFT'($urandom);
        endcase
        if (sel == 8)
            return $urandom_range(0, 1) ? '0 : '1;
        if (sel == 9 || walk == 0 || !cur_mode)
            return rand64();
        if (sel == 7) begin
            // just outside a run
            if ($urandom_range(0, 1) && loaded_base[idx] != 0)
                page = 64'(loaded_base[idx]) - 1;
            else
                page = 64'(loaded_base[idx]) + 64'(loaded_pages[idx]);
        end else begin
            if (loaded_pages[idx] == 0)
                return rand64();
            case ($urandom_range(0, 3))
                0:       off = '0;
                1:       off = 64'(loaded_pages[idx]) - 1;
                default: off = rand64() % 64'(loaded_pages[idx]);
            endcase
            page = 64'(loaded_base[idx]) + off;
        end
        if (page > 64'(PAGE_MAX))
            page = 64'(PAGE_MAX);
        return {page[PAGE_W-1:0], byte_off};
    endfunction

    initial begin
        int phase;
        int n;
        logic [HEADER_W-1:0] hdr;
        logic [RUN_COUNT_W-1:0] cnt;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // raw mode straight out of reset
        xlat_item('1, '1);

        load_run(0, 52'd16, 52'd4);
        load_run(1, 52'd0, 52'd0);
        load_run(2, PAGE_MAX, PAGE_MAX);
        load_run(3, 52'd100, 52'd2);
        load_run(4, 52'd17, 52'd8);

        // empty table misses everything
        set_config(1'b1, 17'd8192, 6'd0);
        xlat_item(64'd0, 32'd7);

        set_config(1'b1, 17'd4096, 6'd5);
        xlat_item(64'd16 * 4096, '1);
        xlat_item(64'd20 * 4096 - 1, 32'd10);
        xlat_item(64'd18 * 4096 + 5, 32'd0);
        xlat_item(64'd0, 32'd5);
        xlat_item(64'd20 * 4096, 32'd100);
        xlat_item('1, '1);
        xlat_item(64'd101 * 4096 + 4095, '1);
        xlat_item(64'd102 * 4096, 32'd3);

        // miss with a 64 KiB header wraps the offset
        set_config(1'b1, 17'd65536, 6'd2);
        xlat_item('1, 32'd1);

        set_config(1'b0, 17'd0, 6'd0);
        xlat_item(64'd0, 32'd0);

        // fill the whole run table before any wider walk
        for (int i = 0; i < MAX_RUNS; i++)
            load_run(RUN_INDEX_W'(i), pick_base(), pick_pages());

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       hdr = '0;
                1:       hdr = 17'd65536;
                2:       hdr = 17'd4096;
                3:       hdr = 17'd8192;
                default: hdr = HEADER_W'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 7))
                0:       cnt = '0;
                1:       cnt = 6'd32;
                2:       cnt = RUN_COUNT_W'($urandom_range(33, 63));
                3:       cnt = 6'd1;
                default: cnt = RUN_COUNT_W'($urandom_range(1, 32));
            endcase
            set_config(1'($urandom_range(0, 4) != 0), hdr, cnt);
            steady = (phase % 6 == 3);
            n = steady ? 150 : $urandom_range(30, 70);
            repeat (n) begin
                if ($urandom_range(0, 99) < 12)
                    load_run(RUN_INDEX_W'($urandom_range(0, MAX_RUNS - 1)),
                             pick_base(), pick_pages());
                else
                    xlat_item(pick_addr(), pick_len());
            end
            steady = 1'b0;
            phase++;
        end

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
